// File: rtl/core/tsis_pkg.sv
// shared types and constants for the table scaler with inverse search
`default_nettype none
package tsis_pkg;

  // fixed field widths
  localparam int WORD_W = 32;
  localparam int POS_W  = 16;
  localparam int OPOS_W = 15;
  localparam int EIDX_W = 10;

  // default geometry
  localparam int TABLE_DEPTH_DEF = 1024;
  localparam int INDEX_SHIFT_DEF = 5;

  // item function codes
  typedef enum logic [1:0] {
    FUNC_LOAD   = 2'd0,
    FUNC_LOOKUP = 2'd1,
    FUNC_SEARCH = 2'd2,
    FUNC_INCR   = 2'd3
  } func_t;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_READ,
    ST_SINIT,
    ST_STEP,
    ST_FIN
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic idle;
    logic write;
    logic read_elem;
    logic search_init;
    logic search_step;
    logic result_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic  in_valid;
    func_t in_func;
    logic  target_zero;
    logic  more;
    logic  out_busy;
  } stat_t;

endpackage
`default_nettype wire

// File: rtl/core/tsis_if.sv
// handshake channel interfaces for items and results
`default_nettype none
interface tsis_item_if;
  import tsis_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [1:0]               func;
  logic [EIDX_W-1:0]        entry_index;
  logic signed [WORD_W-1:0] entry_word;
  logic signed [POS_W-1:0]  position;
  logic signed [POS_W-1:0]  step;
  logic signed [WORD_W-1:0] target;

  modport source (
    output valid, func, entry_index, entry_word, position, step, target,
    input  ready
  );
  modport sink (
    input  valid, func, entry_index, entry_word, position, step, target,
    output ready
  );
endinterface

interface tsis_result_if;
  import tsis_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] scaled_value;
  logic [OPOS_W-1:0]        new_position;

  modport source (
    output valid, scaled_value, new_position,
    input  ready
  );
  modport sink (
    input  valid, scaled_value, new_position,
    output ready
  );
endinterface
`default_nettype wire

// File: rtl/core/tsis_ctrl.sv
// controller state machine sequencing loads, reads and the binary search
`default_nettype none
module tsis_ctrl (
  input  wire             clk,
  input  wire             rst,
  input  tsis_pkg::stat_t st,
  output tsis_pkg::cmd_t  cmd
);
  import tsis_pkg::*;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (st.in_valid) begin
          case (st.in_func)
            FUNC_LOAD:   state_next = ST_WRITE;
            FUNC_SEARCH: state_next = ST_SINIT;
            default:     state_next = ST_READ;
          endcase
        end
      end
      ST_WRITE: state_next = ST_IDLE;
      ST_READ:  state_next = ST_FIN;
      ST_SINIT: state_next = st.target_zero ? ST_FIN : ST_STEP;
      ST_STEP:  state_next = st.more ? ST_STEP : ST_FIN;
      ST_FIN:   state_next = st.out_busy ? ST_FIN : ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd             = '0;
    cmd.idle        = (state == ST_IDLE);
    cmd.write       = (state == ST_WRITE);
    cmd.read_elem   = (state == ST_READ);
    cmd.search_init = (state == ST_SINIT);
    cmd.search_step = (state == ST_STEP);
    cmd.result_load = (state == ST_FIN) && !st.out_busy;
  end

endmodule
`default_nettype wire

// File: rtl/core/tsis_dp.sv
// datapath: item capture, value table, position math, search bounds, result register
`default_nettype none
module tsis_dp #(
  parameter int TABLE_DEPTH = tsis_pkg::TABLE_DEPTH_DEF,
  parameter int INDEX_SHIFT = tsis_pkg::INDEX_SHIFT_DEF
) (
  input  wire             clk,
  input  wire             rst,
  tsis_item_if.sink       item,
  tsis_result_if.source   result,
  input  tsis_pkg::cmd_t  cmd,
  output tsis_pkg::stat_t st
);
  import tsis_pkg::*;

  localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W  = IDX_W + 1;
  localparam int WIDE_W = IDX_W + INDEX_SHIFT + OPOS_W;
  localparam longint PM_RAW = longint'(TABLE_DEPTH - 1) * (longint'(1) << INDEX_SHIFT);
  localparam logic [OPOS_W-1:0] POS_MAX =
    (PM_RAW > 32767) ? 15'd32767 : OPOS_W'(PM_RAW);
  localparam logic [IDX_W-1:0] INIT_MID = IDX_W'(TABLE_DEPTH / 2);

  // captured item
  func_t                    func_q;
  logic [EIDX_W-1:0]        eidx_q;
  logic [WORD_W-1:0]        eword_q;
  logic signed [POS_W-1:0]  pos_q;
  logic signed [POS_W-1:0]  step_q;
  logic signed [WORD_W-1:0] target_q;

  // table and read port
  logic [WORD_W-1:0] mem [TABLE_DEPTH];
  logic [WORD_W-1:0] rdata;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;

  // search bounds
  logic [IDX_W-1:0] lo;
  logic [CNT_W-1:0] hi;
  logic [IDX_W-1:0] mid;
  logic [IDX_W-1:0] lo_next;
  logic [CNT_W-1:0] hi_next;
  logic [CNT_W:0]   mid_sum;
  logic [IDX_W-1:0] mid_next;
  logic             ge;

  // position math
  logic signed [POS_W:0] sum;
  logic [OPOS_W-1:0]     eff_pos;
  logic [16:0]           idx_wide;
  logic [IDX_W-1:0]      elem_addr;
  logic [WIDE_W-1:0]     lo_wide;
  logic                  load_ok;

  // result register
  logic                     out_valid;
  logic signed [WORD_W-1:0] out_value;
  logic [OPOS_W-1:0]        out_pos;

  assign item.ready = cmd.idle;

  // capture the transaction
  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      func_q   <= func_t'(item.func);
      eidx_q   <= item.entry_index;
      eword_q  <= item.entry_word;
      pos_q    <= item.position;
      step_q   <= item.step;
      target_q <= item.target;
    end
  end

  // effective position for lookup or increment
  always_comb begin
    sum = {pos_q[POS_W-1], pos_q} + {step_q[POS_W-1], step_q};
    if (func_q == FUNC_INCR) begin
      if (sum < 0) begin
        eff_pos = '0;
      end else if (sum > $signed({2'b00, POS_MAX})) begin
        eff_pos = POS_MAX;
      end else begin
        eff_pos = sum[OPOS_W-1:0];
      end
    end else begin
      eff_pos = pos_q[POS_W-1] ? '0 : pos_q[OPOS_W-1:0];
    end
  end

  // table index from position, saturated at the last entry
  always_comb begin
    idx_wide = 17'(eff_pos >> INDEX_SHIFT);
    if (idx_wide > 17'(TABLE_DEPTH - 1)) begin
      idx_wide = 17'(TABLE_DEPTH - 1);
    end
    elem_addr = IDX_W'(idx_wide);
  end

  // one bisection step from the word read at mid
  always_comb begin
    ge       = (target_q >= $signed(rdata));
    lo_next  = ge ? mid : lo;
    hi_next  = ge ? hi : {1'b0, mid};
    mid_sum  = {1'b0, CNT_W'(lo_next)} + {1'b0, hi_next};
    mid_next = mid_sum[IDX_W:1];
  end

  // read address select
  always_comb begin
    rd_en = cmd.read_elem || cmd.search_init || cmd.search_step;
    if (cmd.read_elem) begin
      rd_addr = elem_addr;
    end else if (cmd.search_init) begin
      rd_addr = INIT_MID;
    end else begin
      rd_addr = mid_next;
    end
  end

  assign load_ok = ({7'b0, eidx_q} < 17'(TABLE_DEPTH));

  // table memory
  always_ff @(posedge clk) begin
    if (cmd.write && load_ok) begin
      mem[IDX_W'(eidx_q)] <= eword_q;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // search bounds
  always_ff @(posedge clk) begin
    if (cmd.search_init) begin
      lo  <= '0;
      hi  <= CNT_W'(TABLE_DEPTH);
      mid <= INIT_MID;
    end else if (cmd.search_step) begin
      lo  <= lo_next;
      hi  <= hi_next;
      mid <= mid_next;
    end
  end

  assign lo_wide = WIDE_W'(lo) << INDEX_SHIFT;

  // result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.result_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (cmd.result_load) begin
      case (func_q)
        FUNC_LOOKUP: begin
          out_value <= rdata;
          out_pos   <= '0;
        end
        FUNC_INCR: begin
          out_value <= rdata;
          out_pos   <= eff_pos;
        end
        FUNC_SEARCH: begin
          out_value <= '0;
          out_pos   <= lo_wide[OPOS_W-1:0];
        end
        default: begin
          out_value <= '0;
          out_pos   <= '0;
        end
      endcase
    end
  end

  assign result.valid        = out_valid;
  assign result.scaled_value = out_value;
  assign result.new_position = out_pos;

  // status to the controller
  always_comb begin
    st             = '0;
    st.in_valid    = item.valid;
    st.in_func     = func_t'(item.func);
    st.target_zero = (target_q == '0);
    st.more        = ((hi_next - CNT_W'(lo_next)) > CNT_W'(1));
    st.out_busy    = out_valid && !result.ready;
  end

endmodule
`default_nettype wire

// File: rtl/core/table_scaler_with_inverse_search_top.sv
// top level: value table with lookup, saturating increment and inverse search
// load: written in the write state; lookup and increment read the table in the read
// state and register the result in the finish state; new items are taken only in idle
// search: a zero target goes from search init to finish; a nonzero target bisects in
// the step state until one entry remains; output stalls hold the controller in place
// synchronous rst clears the controller and result valid; table undefined until loaded
`default_nettype none
module table_scaler_with_inverse_search_top #(
  parameter int TABLE_DEPTH = tsis_pkg::TABLE_DEPTH_DEF,
  parameter int INDEX_SHIFT = tsis_pkg::INDEX_SHIFT_DEF
) (
  input wire            clk,
  input wire            rst,
  tsis_item_if.sink     item,
  tsis_result_if.source result
);
  import tsis_pkg::*;

  cmd_t  cmd;
  stat_t st;

  // sequencing
  tsis_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .st  (st),
    .cmd (cmd)
  );

  // storage and arithmetic
  tsis_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .INDEX_SHIFT (INDEX_SHIFT)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .result (result),
    .cmd    (cmd),
    .st     (st)
  );

endmodule
`default_nettype wire

// File: dv/tb_table_scaler_with_inverse_search_top.sv
// testbench for the table scaler with inverse search, checked against an in-bench predictor
module tb_table_scaler_with_inverse_search_top;
  import tsis_pkg::*;

  localparam int DEPTH   = TABLE_DEPTH_DEF;
  localparam int SHIFT   = INDEX_SHIFT_DEF;
  localparam int POS_MAX = ((DEPTH - 1) << SHIFT) > 32767 ? 32767 : ((DEPTH - 1) << SHIFT);
  localparam longint WORD_MIN = -(longint'(1) << 31);
  localparam longint WORD_MAX = (longint'(1) << 31) - 1;

  // one item as the sender sees it
  typedef struct {
    func_t                    func;
    logic [EIDX_W-1:0]        entry_index;
    logic signed [WORD_W-1:0] entry_word;
    logic signed [POS_W-1:0]  position;
    logic signed [POS_W-1:0]  step;
    logic signed [WORD_W-1:0] target;
  } scaler_item_t;

  // one result as the receiver sees it
  typedef struct {
    logic signed [WORD_W-1:0] scaled_value;
    logic [OPOS_W-1:0]        new_position;
  } scaled_result_t;

  logic clk = 1'b0;
  logic rst;

  tsis_item_if   item_ch ();
  tsis_result_if result_ch ();

  table_scaler_with_inverse_search_top dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  // mirror of the value table and the expected results in flight
  logic signed [WORD_W-1:0] shadow_table [DEPTH];
  scaled_result_t           pending_results [$];
  int                       last_position = 0;

  int error_count     = 0;
  int results_checked = 0;
  int items_by_func [4] = '{0, 0, 0, 0};
  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // table read at a position, index saturated to the last entry
  function automatic logic signed [WORD_W-1:0] table_at(input int pos);
    int idx;
    idx = pos >> SHIFT;
    if (idx > DEPTH - 1) idx = DEPTH - 1;
    return shadow_table[idx];
  endfunction

  // expected result of one transaction; returns 0 when the item gives no result
  function automatic bit predict_scaler(input scaler_item_t it, output scaled_result_t res);
    int s;
    int lo;
    int hi;
    int mid;
    res.scaled_value = '0;
    res.new_position = '0;
    case (it.func)
      FUNC_LOAD: begin
        if (it.entry_index < DEPTH) shadow_table[it.entry_index] = it.entry_word;
        return 1'b0;
      end
      FUNC_LOOKUP: begin
        s = (it.position < 0) ? 0 : int'(it.position);
        res.scaled_value = table_at(s);
      end
      FUNC_SEARCH: begin
        lo = 0;
        hi = DEPTH;
        // last entry not above the target
        if (it.target != 0) begin
          while (hi - lo > 1) begin
            mid = (lo + hi) >> 1;
            if (it.target >= shadow_table[mid]) lo = mid;
            else hi = mid;
          end
        end
        res.new_position = OPOS_W'((lo << SHIFT) & 'h7fff);
      end
      default: begin
        // 16-bit saturation, then clamp to the table range
        s = int'(it.position) + int'(it.step);
        if (s > 32767) s = 32767;
        if (s < -32768) s = -32768;
        if (s < 0) s = 0;
        if (s > POS_MAX) s = POS_MAX;
        last_position = s;
        res.scaled_value = table_at(s);
        res.new_position = OPOS_W'(s);
      end
    endcase
    return 1'b1;
  endfunction

  // item with random content in every field but the function, which is set to lookup
  function automatic scaler_item_t noise_item();
    scaler_item_t it;
    it.func        = FUNC_LOOKUP;
    it.entry_index = EIDX_W'($urandom);
    it.entry_word  = $urandom;
    it.position    = POS_W'($urandom);
    it.step        = POS_W'($urandom);
    it.target      = $urandom;
    return it;
  endfunction

  // position drawn from the full range, the non-negative range, the edges or small values
  function automatic logic signed [POS_W-1:0] pick_position();
    int edges [8] = '{-32768, -1, 0, 31, 32, 32735, 32736, 32767};
    case ($urandom_range(3))
      0: return POS_W'($urandom);
      1: return POS_W'($urandom_range(32767));
      2: return POS_W'(edges[$urandom_range(7)]);
      default: return POS_W'($urandom_range(64));
    endcase
  endfunction

  // send one transaction and record its expected result on acceptance
  task automatic send_item(input scaler_item_t it);
    scaled_result_t res;
    while ($urandom_range(99) < sender_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid       <= 1'b1;
    item_ch.func        <= it.func;
    item_ch.entry_index <= it.entry_index;
    item_ch.entry_word  <= it.entry_word;
    item_ch.position    <= it.position;
    item_ch.step        <= it.step;
    item_ch.target      <= it.target;
    do @(posedge clk); while (item_ch.ready !== 1'b1);
    if (predict_scaler(it, res)) pending_results.push_back(res);
    items_by_func[int'(it.func)]++;
  endtask

  // result checker and receiver stalls
  always @(posedge clk) begin : result_checker
    scaled_result_t exp_res;
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
        if (pending_results.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result, got value %0d position %0d", $time,
                   result_ch.scaled_value, result_ch.new_position);
        end else begin
          exp_res = pending_results.pop_front();
          results_checked++;
          if (result_ch.scaled_value !== exp_res.scaled_value) begin
            error_count++;
            $display("%0t: scaled_value mismatch, expected %0d, got %0d", $time,
                     exp_res.scaled_value, result_ch.scaled_value);
          end
          if (result_ch.new_position !== exp_res.new_position) begin
            error_count++;
            $display("%0t: new_position mismatch, expected %0d, got %0d", $time,
                     exp_res.new_position, result_ch.new_position);
          end
        end
      end
      result_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // load every entry with a non-decreasing sequence spanning the word range
  task automatic test_table_fill();
    scaler_item_t it;
    longint       acc;
    acc = WORD_MIN + longint'($urandom_range(1 << 20, 1));
    for (int i = 0; i < DEPTH; i++) begin
      if (i > 0) acc += longint'($urandom_range(8_400_000));
      if (acc > WORD_MAX) acc = WORD_MAX;
      it             = noise_item();
      it.func        = FUNC_LOAD;
      it.entry_index = EIDX_W'(i);
      it.entry_word  = acc[WORD_W-1:0];
      send_item(it);
    end
  endtask

  // lookup at negative, boundary and top positions
  task automatic test_lookup_edges();
    scaler_item_t it;
    int positions [7] = '{-32768, -1, 0, 31, 32, 1000, 32767};
    foreach (positions[i]) begin
      it          = noise_item();
      it.func     = FUNC_LOOKUP;
      it.position = POS_W'(positions[i]);
      send_item(it);
    end
  endtask

  // increment with saturation and clamping at both ends
  task automatic test_increment_saturation();
    scaler_item_t it;
    int inc_pos  [6] = '{100, 32767, -32768, 32700, 10, 32736};
    int inc_step [6] = '{50, 32767, -32768, 100, -20, 0};
    foreach (inc_pos[i]) begin
      it          = noise_item();
      it.func     = FUNC_INCR;
      it.position = POS_W'(inc_pos[i]);
      it.step     = POS_W'(inc_step[i]);
      send_item(it);
    end
  endtask

  // inverse search: zero target, below first, exact, between, at and above last
  task automatic test_inverse_search_edges();
    scaler_item_t it;
    logic signed [WORD_W-1:0] targets [6];
    targets = '{0, shadow_table[0] - 1, shadow_table[500], shadow_table[500] + 1,
                shadow_table[DEPTH-1], WORD_MAX[WORD_W-1:0]};
    foreach (targets[i]) begin
      it        = noise_item();
      it.func   = FUNC_SEARCH;
      it.target = targets[i];
      send_item(it);
    end
    // word extremes at both ends of the table
    it             = noise_item();
    it.func        = FUNC_LOAD;
    it.entry_index = '0;
    it.entry_word  = WORD_MIN[WORD_W-1:0];
    send_item(it);
    it             = noise_item();
    it.func        = FUNC_LOAD;
    it.entry_index = EIDX_W'(DEPTH - 1);
    it.entry_word  = WORD_MAX[WORD_W-1:0];
    send_item(it);
    it        = noise_item();
    it.func   = FUNC_SEARCH;
    it.target = WORD_MIN[WORD_W-1:0];
    send_item(it);
    it          = noise_item();
    it.func     = FUNC_LOOKUP;
    it.position = '0;
    send_item(it);
  endtask

  // random mix of all functions under one sender idle and receiver stall setting
  task automatic test_random_mix(input int idle_pct, input int stall_pct, input int count);
    scaler_item_t it;
    longint       lo_v;
    longint       hi_v;
    longint       v;
    int           idx;
    int           r;
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    for (int n = 0; n < count; n++) begin
      it = noise_item();
      r  = $urandom_range(99);
      if (r < 20) begin
        // reload, mostly keeping the table in order
        it.func = FUNC_LOAD;
        idx     = $urandom_range(DEPTH - 1);
        lo_v    = (idx == 0) ? WORD_MIN : longint'(shadow_table[idx-1]);
        hi_v    = (idx == DEPTH - 1) ? WORD_MAX : longint'(shadow_table[idx+1]);
        if ($urandom_range(7) != 0 && lo_v <= hi_v)
          v = lo_v + longint'($urandom_range(32'(hi_v - lo_v)));
        else
          v = longint'($signed($urandom));
        it.entry_index = EIDX_W'(idx);
        it.entry_word  = v[WORD_W-1:0];
      end else if (r < 45) begin
        it.func     = FUNC_LOOKUP;
        it.position = pick_position();
      end else if (r < 72) begin
        it.func = FUNC_SEARCH;
        idx     = $urandom_range(DEPTH - 1);
        case ($urandom_range(9))
          0:          v = 0;
          1, 2, 3, 4: v = longint'(shadow_table[idx]);
          5, 6:       v = longint'(shadow_table[idx]) + longint'($urandom_range(2)) - 1;
          7:          v = longint'($signed($urandom));
          8:          v = $urandom_range(1) ? WORD_MAX : WORD_MIN;
          default:    v = longint'(shadow_table[0]) - longint'($urandom_range(1000, 1));
        endcase
        if (v > WORD_MAX) v = WORD_MAX;
        if (v < WORD_MIN) v = WORD_MIN;
        it.target = v[WORD_W-1:0];
      end else begin
        // increments mostly chain from the previous position
        it.func     = FUNC_INCR;
        it.position = ($urandom_range(9) < 6) ? POS_W'(last_position) : pick_position();
        case ($urandom_range(3))
          0:       it.step = POS_W'($urandom);
          1:       it.step = POS_W'(int'($urandom_range(128)) - 64);
          2:       it.step = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
          default: it.step = POS_W'(int'($urandom_range(2048)) - 1024);
        endcase
      end
      send_item(it);
    end
  endtask

  // main sequence
  initial begin
    rst                 <= 1'b1;
    item_ch.valid       <= 1'b0;
    item_ch.func        <= FUNC_LOAD;
    item_ch.entry_index <= '0;
    item_ch.entry_word  <= '0;
    item_ch.position    <= '0;
    item_ch.step        <= '0;
    item_ch.target      <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_table_fill();
    test_lookup_edges();
    test_increment_saturation();
    test_inverse_search_edges();
    test_random_mix(0, 0, 90);
    test_random_mix(45, 0, 90);
    test_random_mix(0, 45, 90);
    test_random_mix(35, 35, 90);
    item_ch.valid <= 1'b0;

    // drain and let the pipeline settle
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d loads, %0d lookups, %0d searches, %0d increments",
             items_by_func[0], items_by_func[1], items_by_func[2], items_by_func[3]);
    $display("%0d results compared across four backpressure phases, %0d errors",
             results_checked, error_count);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("watchdog expired with %0d results outstanding", pending_results.size());
    $display("simulation failed");
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/tsis_pkg.sv
rtl/core/tsis_if.sv
rtl/core/tsis_ctrl.sv
rtl/core/tsis_dp.sv
rtl/core/table_scaler_with_inverse_search_top.sv
dv/tb_table_scaler_with_inverse_search_top.sv
